// File: design/tds_pkg.sv
// ---------------------------------------------------------------------------
// tds_pkg: shared types and constants of the transmit descriptor splitter
// Request and descriptor payload structs, boundary constants, fragment
// unit result struct.
// ---------------------------------------------------------------------------
package tds_pkg;

  // DMA boundary that no fragment may cross; must be a power of two
  localparam int SEG_BOUNDARY = 4096;
  localparam int BND_BITS     = $clog2(SEG_BOUNDARY);
  localparam logic [63:0] BND_MASK = 64'(SEG_BOUNDARY - 1);

  // Most descriptors one request may produce
  localparam int MAX_RESULTS = 18;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Descriptor kinds
  localparam logic DESC_FRAG = 1'b0;
  localparam logic DESC_VLAN = 1'b1;

  typedef struct packed {
    logic        first_segment;
    logic        vlan_present;
    logic [15:0] tag_ctrl;
    logic [15:0] packet_length;
    logic [63:0] segment_address;
    logic [15:0] segment_length;
  } in_req_t;

  typedef struct packed {
    logic        desc_kind;
    logic [63:0] frag_address;
    logic [15:0] frag_length;
    logic        end_of_packet;
    logic [15:0] tag_value;
    logic        last_of_run;
  } out_desc_t;

  // Result of one fragment step
  typedef struct packed {
    logic [15:0] len;
    logic [63:0] next_addr;
    logic [15:0] seg_left;
    logic [15:0] remaining;
    logic        eop;
    logic        last;
  } frag_res_t;

endpackage

// File: design/tds_frag_unit.sv
// ---------------------------------------------------------------------------
// tds_frag_unit: one boundary-safe fragment cut
// Given the current address, bytes left in the segment and bytes left in
// the packet, compute the next fragment and the updated counters.
// ---------------------------------------------------------------------------
module tds_frag_unit (
  input  logic [63:0]         addr,
  input  logic [15:0]         seg_left,
  input  logic [15:0]         remaining,
  output tds_pkg::frag_res_t  res
);
  import tds_pkg::*;

  logic [16:0] room;
  logic [15:0] len;

  // bytes up to the next boundary, 1 .. SEG_BOUNDARY
  assign room = 17'(SEG_BOUNDARY) - 17'(addr[BND_BITS-1:0]);
  assign len  = ({1'b0, seg_left} < room) ? seg_left : room[15:0];

  always_comb begin
    res.len       = len;
    res.next_addr = (addr | BND_MASK) + 64'd1;
    res.seg_left  = seg_left - len;
    res.remaining = remaining - len;
    res.eop       = (remaining - len) == 16'd0;
    res.last      = (seg_left - len) == 16'd0;
  end

endmodule

// File: design/tx_descriptor_splitter.sv
// ---------------------------------------------------------------------------
// tx_descriptor_splitter: VLAN option and boundary-safe DMA descriptors
// Takes one buffer segment per request and emits an optional VLAN tag
// option descriptor followed by fragments that never cross SEG_BOUNDARY.
// ---------------------------------------------------------------------------
// Flow: an accepted request is latched into the working registers; each
// descriptor then goes to the output register in turn, waiting while it
// is held. Requests are taken only in idle, after the last descriptor;
// the single fragment unit cuts one fragment a cycle when the slot is free.
// Reset (rst_n low, synchronous): sequencer idle, output empty, remembered
// tag and remaining packet length cleared to zero.
module tx_descriptor_splitter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tds_pkg::in_req_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tds_pkg::out_desc_t  out_data
);
  import tds_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VLAN,
    ST_FRAG
  } state_t;

  state_t          state_r, state_nxt;
  logic [63:0]     addr_r, addr_nxt;
  logic [15:0]     seg_left_r, seg_left_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_desc_t       out_data_r, out_data_nxt;

  frag_res_t       frag;
  logic            slot_free;
  logic            accept;
  logic [15:0]     pkt_tag;
  logic [15:0]     rem_start;
  logic [CNT_W-1:0] cnt_inc;

  // Single fragment unit, fed from the working registers each cycle
  tds_frag_unit u_frag (
    .addr      (addr_r),
    .seg_left  (seg_left_r),
    .remaining (rem_r),
    .res       (frag)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  // Output register can take a new descriptor when empty or being drained
  assign slot_free = !out_valid_r || out_ready;
  assign pkt_tag   = in_data.vlan_present ? in_data.tag_ctrl : 16'd0;
  assign rem_start = in_data.first_segment ? in_data.packet_length : rem_r;
  assign cnt_inc   = cnt_r + CNT_W'(1);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    seg_left_nxt  = seg_left_r;
    rem_nxt       = rem_r;
    tag_nxt       = tag_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the held descriptor once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Latch the segment and load the packet length on a first segment
          addr_nxt     = in_data.segment_address;
          seg_left_nxt = in_data.segment_length;
          rem_nxt      = rem_start;
          cnt_nxt      = '0;
          if (in_data.first_segment && (pkt_tag != tag_r)) begin
            tag_nxt   = pkt_tag;
            state_nxt = ST_VLAN;
          end else begin
            state_nxt = ST_FRAG;
          end
        end
      end
      ST_VLAN: begin
        // Announce the new tag ahead of the fragments
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.desc_kind     = DESC_VLAN;
          out_data_nxt.frag_address  = 64'd0;
          out_data_nxt.frag_length   = 16'd0;
          out_data_nxt.end_of_packet = 1'b0;
          out_data_nxt.tag_value     = tag_r;
          out_data_nxt.last_of_run   = 1'b0;
          cnt_nxt                    = cnt_inc;
          state_nxt                  = ST_FRAG;
        end
      end
      ST_FRAG: begin
        // Cut one fragment per cycle while the output slot is free; always at least one per segment
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.desc_kind     = DESC_FRAG;
          out_data_nxt.frag_address  = addr_r;
          out_data_nxt.frag_length   = frag.len;
          out_data_nxt.end_of_packet = frag.eop;
          out_data_nxt.tag_value     = 16'd0;
          out_data_nxt.last_of_run   = frag.last;
          addr_nxt                   = frag.next_addr;
          seg_left_nxt               = frag.seg_left;
          rem_nxt                    = frag.remaining;
          cnt_nxt                    = cnt_inc;
          // Stop at segment end or at the descriptor cap
          if (frag.last || (cnt_inc == CNT_W'(MAX_RESULTS))) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tag_r       <= 16'd0;
      rem_r       <= 16'd0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r       <= tag_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
    end
    addr_r     <= addr_nxt;
    seg_left_r <= seg_left_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
